[rtl/core/gammatone_band_filter_macros.svh]
// Assertion macros shared by the gammatone band filter RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef GAMMATONE_BAND_FILTER_MACROS_SVH
`define GAMMATONE_BAND_FILTER_MACROS_SVH

// same-cycle implication
`define GBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbf assertion failed");

// next-cycle implication
`define GBF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbf assertion failed");

`endif

[rtl/core/gbf_pkg.sv]
// Types and constants of the gammatone band filter.
// No dependencies; used by the interface users, controller, datapath and top.
package gbf_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FIRST_B0 = 4'd0,
        REG_REST_B0  = 4'd1,
        REG_B1_SEC0  = 4'd2,
        REG_B1_SEC1  = 4'd3,
        REG_B1_SEC2  = 4'd4,
        REG_B1_SEC3  = 4'd5,
        REG_FB_A1    = 4'd6,
        REG_FB_A2    = 4'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B0,
        ST_Y,
        ST_ACC,
        ST_D1,
        ST_D2,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_B0,
        OP_Y,
        OP_ACC,
        OP_D1,
        OP_D2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_x;
        logic load_out;
    } gbf_cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           last_out;
    } out_word_t;

endpackage

[rtl/core/gbf_stream_if.sv]
// Valid/ready stream channel carrying one word of a given type.
// No dependencies; word types come from gbf_pkg at the instance.
interface gbf_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/gammatone_band_filter.sv]
// Top level of one gammatone filterbank band: four cascaded TDF-II biquads.
// Depends on gbf_pkg, gbf_stream_if, gbf_ctrl and gbf_datapath.
//
// Usage:
//   in_stream carries one input word per sample (sample_in Q1.15, last_in).
//   out_stream returns one word per input (sample_out Q1.15 saturated,
//   last_out copied from last_in). A word moves when valid and ready are high.
//   Coefficients are written through cfg_we/cfg_index/cfg_data while the
//   block is idle; indexes 0..7 follow the register list, others are ignored.
// Timing:
//   One multiplier is shared by all sections; each section steps through the
//   states B0, Y, ACC, D1 and D2 (four products plus the delay updates).
//   out_stream.valid rises when the result is loaded from the OUT state after
//   the last section, and the block takes no new sample until that load.
// Reset:
//   rst_n clears coefficients and all section delays to zero at once; the
//   block is ready for input as soon as reset is released.
// Stall:
//   The output word is held in a register; the next sample is accepted and
//   filtered while it waits, and the block holds off only when a second
//   result is ready and the first one has still not been taken.
module gammatone_band_filter #(
    parameter int NUM_SECTIONS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gbf_stream_if.sink                          in_stream,
    gbf_stream_if.source                        out_stream,
    input  logic                                cfg_we,
    input  logic [gbf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [gbf_pkg::COEF_WIDTH-1:0]      cfg_data
);
    import gbf_pkg::*;

    localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    gbf_cmd_t         cmd;
    logic [SEC_W-1:0] sec;

    gbf_ctrl #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stream.valid),
        .in_ready  (in_stream.ready),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .cmd       (cmd),
        .sec       (sec)
    );

    gbf_datapath #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sec       (sec),
        .in_word   (in_stream.data),
        .out_word  (out_stream.data)
    );

endmodule

[rtl/core/gbf_ctrl.sv]
// Sequencer of the gammatone band filter: steps sections and handshakes.
// Depends on gbf_pkg and gammatone_band_filter_macros.svh.
`include "gammatone_band_filter_macros.svh"

module gbf_ctrl #(
    parameter int NUM_SECTIONS = 4,
    parameter int SEC_W        = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gbf_pkg::gbf_cmd_t    cmd,
    output logic [SEC_W-1:0]     sec
);
    import gbf_pkg::*;

    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

    state_t           state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sec       = sec_reg;

    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        case (state_reg)
            ST_IDLE:
            begin
                sec_next = '0;
                if (accept)
                    state_next = ST_B0;
            end
            ST_B0:  state_next = ST_Y;
            ST_Y:   state_next = ST_ACC;
            ST_ACC: state_next = ST_D1;
            ST_D1:  state_next = ST_D2;
            ST_D2:
            begin
                if (sec_reg == LAST_SEC)
                    state_next = ST_OUT;
                else
                begin
                    state_next = ST_B0;
                    sec_next   = sec_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load_x   = accept;
        cmd.load_out = (state_reg == ST_OUT) && out_free;
        case (state_reg)
            ST_B0:   cmd.op = OP_B0;
            ST_Y:    cmd.op = OP_Y;
            ST_ACC:  cmd.op = OP_ACC;
            ST_D1:   cmd.op = OP_D1;
            ST_D2:   cmd.op = OP_D2;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GBF_ASSERT_NXT(a_accept_starts, accept, state_reg == ST_B0)
    `GBF_ASSERT_NXT(a_last_sec_done, (state_reg == ST_D2) && (sec_reg == LAST_SEC),
                    state_reg == ST_OUT)
    `GBF_ASSERT_NXT(a_out_loaded, (state_reg == ST_OUT) && out_free,
                    (state_reg == ST_IDLE) && out_valid_reg)
    `GBF_ASSERT_IMP(a_sec_range, state_reg != ST_IDLE, sec_reg <= LAST_SEC)

endmodule

[rtl/core/gbf_datapath.sv]
// Datapath: coefficient registers, shared multiplier, section delays, output word.
// Depends on gbf_pkg; driven by gbf_ctrl commands.
module gbf_datapath #(
    parameter int NUM_SECTIONS = 4,
    parameter int SEC_W        = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gbf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [gbf_pkg::COEF_WIDTH-1:0]         cfg_data,
    input  gbf_pkg::gbf_cmd_t                      cmd,
    input  logic [SEC_W-1:0]                       sec,
    input  gbf_pkg::in_word_t                      in_word,
    output gbf_pkg::out_word_t                     out_word
);
    import gbf_pkg::*;

    localparam int SIG_WIDTH   = 32;
    localparam int SIG_FRAC    = 24;
    localparam int STATE_WIDTH = 40;
    localparam int COEF_FRAC   = COEF_WIDTH - 3;
    localparam int PROD_WIDTH  = COEF_WIDTH + SIG_WIDTH;
    localparam int RND_WIDTH   = PROD_WIDTH - COEF_FRAC + 1;
    localparam int SUM_WIDTH   = STATE_WIDTH + 2;
    localparam int IN_SHIFT    = SIG_FRAC - (SAMPLE_WIDTH - 1);
    localparam int OUT_WIDTH   = SIG_WIDTH + 1;
    localparam int NUM_B1      = 4;
    localparam int B1_W        = 2;

    localparam logic signed [PROD_WIDTH-1:0] ROUND_ADD = PROD_WIDTH'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [OUT_WIDTH-1:0]  OUT_ADD   = OUT_WIDTH'(1) <<< (IN_SHIFT - 1);

    function automatic logic signed [SIG_WIDTH-1:0] sat_sig(logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = (SUM_WIDTH'(1) <<< (SIG_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi[SIG_WIDTH-1:0];
        else if (v < lo)
            return lo[SIG_WIDTH-1:0];
        return v[SIG_WIDTH-1:0];
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = (SUM_WIDTH'(1) <<< (STATE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi[STATE_WIDTH-1:0];
        else if (v < lo)
            return lo[STATE_WIDTH-1:0];
        return v[STATE_WIDTH-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        logic signed [OUT_WIDTH-1:0] v);
        logic signed [OUT_WIDTH-1:0] hi;
        logic signed [OUT_WIDTH-1:0] lo;
        hi = (OUT_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi[SAMPLE_WIDTH-1:0];
        else if (v < lo)
            return lo[SAMPLE_WIDTH-1:0];
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    logic signed [COEF_WIDTH-1:0]  first_b0_reg;
    logic signed [COEF_WIDTH-1:0]  rest_b0_reg;
    logic signed [COEF_WIDTH-1:0]  b1_reg [NUM_B1];
    logic signed [COEF_WIDTH-1:0]  fb_a1_reg;
    logic signed [COEF_WIDTH-1:0]  fb_a2_reg;

    logic signed [STATE_WIDTH-1:0] d1_reg [NUM_SECTIONS];
    logic signed [STATE_WIDTH-1:0] d2_reg [NUM_SECTIONS];

    logic signed [SIG_WIDTH-1:0]   x_reg;
    logic signed [SIG_WIDTH-1:0]   y_reg;
    logic signed [SUM_WIDTH-1:0]   acc_reg;
    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic                          last_reg;
    out_word_t                     out_reg;

    logic signed [COEF_WIDTH-1:0]  coef_sel;
    logic signed [SIG_WIDTH-1:0]   sig_sel;
    logic signed [PROD_WIDTH-1:0]  prod_next;
    logic signed [PROD_WIDTH-1:0]  rnd_full;
    logic signed [RND_WIDTH-1:0]   rnd;
    logic [B1_W-1:0]               b1_idx;
    logic signed [SUM_WIDTH-1:0]   y_sum;
    logic signed [SUM_WIDTH-1:0]   acc_sum;
    logic signed [SUM_WIDTH-1:0]   d1_sum;
    logic signed [SUM_WIDTH-1:0]   d2_neg;
    logic signed [OUT_WIDTH-1:0]   out_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_b0_reg <= '0;
            rest_b0_reg  <= '0;
            fb_a1_reg    <= '0;
            fb_a2_reg    <= '0;
            for (int i = 0; i < NUM_B1; i++)
                b1_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_B0: first_b0_reg <= cfg_data;
                REG_REST_B0:  rest_b0_reg  <= cfg_data;
                REG_B1_SEC0:  b1_reg[0]    <= cfg_data;
                REG_B1_SEC1:  b1_reg[1]    <= cfg_data;
                REG_B1_SEC2:  b1_reg[2]    <= cfg_data;
                REG_B1_SEC3:  b1_reg[3]    <= cfg_data;
                REG_FB_A1:    fb_a1_reg    <= cfg_data;
                REG_FB_A2:    fb_a2_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // sections past the fourth reuse the last b1
    always_comb
    begin
        if (32'(sec) >= NUM_B1 - 1)
            b1_idx = B1_W'(NUM_B1 - 1);
        else
            b1_idx = B1_W'(sec);
    end

    always_comb
    begin
        case (cmd.op)
            OP_B0:
            begin
                coef_sel = (sec == '0) ? first_b0_reg : rest_b0_reg;
                sig_sel  = x_reg;
            end
            OP_Y:
            begin
                coef_sel = b1_reg[b1_idx];
                sig_sel  = x_reg;
            end
            OP_ACC:
            begin
                coef_sel = fb_a1_reg;
                sig_sel  = y_reg;
            end
            OP_D1:
            begin
                coef_sel = fb_a2_reg;
                sig_sel  = y_reg;
            end
            default:
            begin
                coef_sel = '0;
                sig_sel  = '0;
            end
        endcase
    end

    assign prod_next = coef_sel * sig_sel;
    assign rnd_full  = (prod_reg + ROUND_ADD) >>> COEF_FRAC;
    assign rnd       = rnd_full[RND_WIDTH-1:0];

    assign y_sum     = SUM_WIDTH'(rnd) + SUM_WIDTH'(d1_reg[sec]);
    assign acc_sum   = SUM_WIDTH'(rnd) + SUM_WIDTH'(d2_reg[sec]);
    assign d1_sum    = acc_reg - SUM_WIDTH'(rnd);
    assign d2_neg    = -SUM_WIDTH'(rnd);
    assign out_shift = (OUT_WIDTH'(y_reg) + OUT_ADD) >>> IN_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SECTIONS; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_D1:   d1_reg[sec] <= sat_state(d1_sum);
                OP_D2:   d2_reg[sec] <= sat_state(d2_neg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_x)
        begin
            x_reg    <= SIG_WIDTH'(in_word.sample_in) <<< IN_SHIFT;
            last_reg <= in_word.last_in;
        end
        case (cmd.op)
            OP_Y:    y_reg   <= sat_sig(y_sum);
            OP_ACC:  acc_reg <= acc_sum;
            OP_D2:   x_reg   <= y_reg;
            default: ;
        endcase
        if (cmd.load_out)
        begin
            out_reg.sample_out <= sat_sample(out_shift);
            out_reg.last_out   <= last_reg;
        end
    end

    assign out_word = out_reg;

endmodule

[tb/tb_gammatone_band_filter.sv]
// Self-checking testbench for one gammatone filterbank band (four TDF-II biquads).
// Depends on gbf_pkg, gbf_stream_if and gammatone_band_filter; a scoreboard class
// predicts each output word in fixed point and checks words in order.
`timescale 1ns / 100ps

module tb_gammatone_band_filter;
    import gbf_pkg::*;

    localparam int NUM_SECTIONS  = 4;
    localparam int NUM_COEF_REGS = 8;
    localparam int SIG_WIDTH     = 32;
    localparam int STATE_WIDTH   = 40;
    localparam int SIG_FRAC      = 24;
    localparam int COEF_FRAC     = COEF_WIDTH - 3;
    localparam int IN_SHIFT      = SIG_FRAC - (SAMPLE_WIDTH - 1);

    localparam logic [CFG_INDEX_WIDTH-1:0] FIRST_UNUSED_INDEX = 4'd8;
    localparam logic [CFG_INDEX_WIDTH-1:0] LAST_UNUSED_INDEX  = 4'd15;

    localparam logic [COEF_WIDTH-1:0] COEF_ONE  = 32'sh2000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_ZERO = 32'sh0000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_MAX  = 32'sh7FFF_FFFF;
    localparam logic [COEF_WIDTH-1:0] COEF_MIN  = 32'sh8000_0000;

    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 115;
    localparam int MAX_GAP       = 11;
    localparam int HOLD_AFTER    = 300;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;

    class band_scoreboard;
        logic signed [COEF_WIDTH-1:0]  coef [NUM_COEF_REGS];
        logic signed [STATE_WIDTH-1:0] delay_one [NUM_SECTIONS];
        logic signed [STATE_WIDTH-1:0] delay_two [NUM_SECTIONS];
        out_word_t expected_words [$];
        int mismatches;

        function new();
            foreach (coef[i])
                coef[i] = '0;
            foreach (delay_one[i])
            begin
                delay_one[i] = '0;
                delay_two[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [COEF_WIDTH-1:0] value);
            if (index < NUM_COEF_REGS)
                coef[index] = value;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            hi = (longint'(1) << (w - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function longint mul_round(longint c, longint s);
            return (c * s + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        endfunction

        function void note_sample(in_word_t w);
            longint x;
            longint y;
            longint b0;
            longint b1;
            longint a1;
            longint a2;
            int s;
            out_word_t r;
            a1 = coef[REG_FB_A1];
            a2 = coef[REG_FB_A2];
            x = longint'($signed(w.sample_in)) <<< IN_SHIFT;
            y = 0;
            for (s = 0; s < NUM_SECTIONS; s++)
            begin
                b0 = (s == 0) ? coef[REG_FIRST_B0] : coef[REG_REST_B0];
                b1 = coef[(s < 4) ? REG_B1_SEC0 + s : REG_B1_SEC3];
                y = clamp(mul_round(b0, x) + delay_one[s], SIG_WIDTH);
                delay_one[s] = STATE_WIDTH'(clamp(mul_round(b1, x) - mul_round(a1, y)
                                                  + delay_two[s], STATE_WIDTH));
                delay_two[s] = STATE_WIDTH'(clamp(-mul_round(a2, y), STATE_WIDTH));
                x = y;
            end
            r.sample_out = SAMPLE_WIDTH'(clamp((y + (longint'(1) << (IN_SHIFT - 1)))
                                               >>> IN_SHIFT, SAMPLE_WIDTH));
            r.last_out = w.last_in;
            expected_words.push_back(r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual sample_out %0d last_out %0b",
                         $time, $signed(got.sample_out), got.last_out);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.sample_out !== want.sample_out)
            begin
                $display("%0t: sample_out expected %0d actual %0d", $time,
                         $signed(want.sample_out), $signed(got.sample_out));
                mismatches++;
            end
            if (got.last_out !== want.last_out)
            begin
                $display("%0t: last_out expected %0b actual %0b", $time,
                         want.last_out, got.last_out);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEF_WIDTH-1:0] cfg_data;
    bit steady;
    int cycle_count;
    band_scoreboard sb = new();

    gbf_stream_if #(.word_t(in_word_t))  in_ch ();
    gbf_stream_if #(.word_t(out_word_t)) out_ch ();

    gammatone_band_filter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [COEF_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(index, value);
    endtask

    task automatic load_coefs(input logic [COEF_WIDTH-1:0] first_b0, rest_b0,
                              b1_s0, b1_s1, b1_s2, b1_s3, a1, a2);
        write_reg(REG_FIRST_B0, first_b0);
        write_reg(REG_REST_B0, rest_b0);
        write_reg(REG_B1_SEC0, b1_s0);
        write_reg(REG_B1_SEC1, b1_s1);
        write_reg(REG_B1_SEC2, b1_s2);
        write_reg(REG_B1_SEC3, b1_s3);
        write_reg(REG_FB_A1, a1);
        write_reg(REG_FB_A2, a2);
    endtask

    task automatic send_word(input logic [SAMPLE_WIDTH-1:0] sample, input logic last);
        int gap;
        in_word_t w;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        w.sample_in = sample;
        w.last_in   = last;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_sample(w);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // b0/b1 within +-1.0; a1, a2 inside the stability triangle
    function automatic logic [COEF_WIDTH-1:0] span_coef(longint bound);
        return COEF_WIDTH'(longint'($urandom_range(0, 32'(2 * bound))) - bound);
    endfunction

    task automatic random_config(input bit wild);
        longint a2;
        longint a1_bound;
        if (wild)
            load_coefs($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom());
        else
        begin
            a2 = longint'($signed(span_coef(longint'(COEF_ONE) * 9 / 10)));
            a1_bound = (longint'(COEF_ONE) + a2) * 9 / 10;
            load_coefs(span_coef(longint'(COEF_ONE) / 4), span_coef(COEF_ONE),
                       span_coef(COEF_ONE), span_coef(COEF_ONE),
                       span_coef(COEF_ONE), span_coef(COEF_ONE),
                       span_coef(a1_bound), COEF_WIDTH'(a2));
        end
        write_reg(CFG_INDEX_WIDTH'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                  $urandom());
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] next_sample(logic [SAMPLE_WIDTH-1:0] prev);
        case ($urandom_range(0, 4))
            0, 1:    return SAMPLE_WIDTH'($urandom());
            2:       return SAMPLE_WIDTH'(int'($urandom_range(0, 2048)) - 1024);
            3:       return prev;
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    initial
    begin
        int phase;
        int n;
        logic [SAMPLE_WIDTH-1:0] prev;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        steady       = 1'b0;
        cycle_count  = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // coefficients still at reset
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        drain();

        // unity pass-through, writes to unknown indexes must not disturb it
        load_coefs(COEF_ONE, COEF_ONE, COEF_ZERO, COEF_ZERO,
                   COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        write_reg(FIRST_UNUSED_INDEX, '1);
        write_reg(LAST_UNUSED_INDEX, '1);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        send_word(16'sh0000, 1'b0);
        send_word(16'sh0001, 1'b1);
        send_word(16'shFFFF, 1'b0);
        send_word(16'sh5555, 1'b1);
        send_word(16'shAAAA, 1'b0);
        send_word(16'sh0000, 1'b1);
        drain();

        // internal and output saturation
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                   COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        send_word(16'sh0064, 1'b0);
        send_word(16'shFF9C, 1'b1);
        drain();
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                   COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0064, 1'b1);
        send_word(16'shFF9C, 1'b0);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady = (phase % 4 == 1);
            random_config(phase % 4 == 3);
            prev = '0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                prev = next_sample(prev);
                send_word(prev, $urandom_range(0, 7) == 0);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side; one long hold-off lets the block fill and stall its input
    initial
    begin
        int gap;
        int words_seen;
        out_ch.ready = 1'b0;
        words_seen = 0;
        wait (rst_n);
        forever
        begin
            if (words_seen == HOLD_AFTER)
                gap = LONG_HOLD;
            else
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            sb.check_word(out_ch.data);
            words_seen++;
        end
    end

endmodule
